// ----- sv/hta_pkg.sv -----
// ----------------------------------------------------------------------------
// hta_pkg
// Command and status codes, and the control and status bundles that pass
// between the allocator controller and its datapath.
// ----------------------------------------------------------------------------
package hta_pkg;

    localparam logic [2:0] CMD_CREATE  = 3'd0;
    localparam logic [2:0] CMD_DESTROY = 3'd1;
    localparam logic [2:0] CMD_ALLOC   = 3'd2;
    localparam logic [2:0] CMD_GET     = 3'd3;
    localparam logic [2:0] CMD_FREE    = 3'd4;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_BAD_INST = 3'd1;
    localparam logic [2:0] ST_NULL     = 3'd2;
    localparam logic [2:0] ST_FULL     = 3'd3;
    localparam logic [2:0] ST_NO_INST  = 3'd4;
    localparam logic [2:0] ST_EMPTY    = 3'd5;

    typedef struct packed {
        logic       load;
        logic       clr_step;
        logic       create;
        logic       kill;
        logic       sweep_step;
        logic       a_read;
        logic       a_check;
        logic       rem_step;
        logic       h_read;
        logic       h_check;
        logic       set_st;
        logic [2:0] st_code;
        logic       publish;
    } hta_cmd_t;

    typedef struct packed {
        logic [2:0] command;
        logic       inst_ok;
        logic       pl_zero;
        logic       h_zero;
        logic       rem_done;
        logic       sweep_last;
        logic       clr_last;
        logic       slot_free;
        logic       tries_last;
        logic       out_busy;
    } hta_stat_t;

endpackage

// ----- sv/hta_ctrl.sv -----
// ----------------------------------------------------------------------------
// hta_ctrl
// Sequencer for the allocator: clearing pass, command decode, slot scan,
// handle reduction, table sweep and result hand-off.
// ----------------------------------------------------------------------------
module hta_ctrl import hta_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  hta_stat_t stat,
    output hta_cmd_t  cmd
);

    localparam logic [3:0] S_CLR   = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_EXEC  = 4'd2;
    localparam logic [3:0] S_SWEEP = 4'd3;
    localparam logic [3:0] S_AREAD = 4'd4;
    localparam logic [3:0] S_ACHK  = 4'd5;
    localparam logic [3:0] S_REM   = 4'd6;
    localparam logic [3:0] S_HREAD = 4'd7;
    localparam logic [3:0] S_HCHK  = 4'd8;
    localparam logic [3:0] S_FIN   = 4'd9;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLR;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_ready = (state_reg == S_IDLE);

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_CLR: begin
                cmd.clr_step = 1'b1;
                if (stat.clr_last) state_next = S_IDLE;
            end
            S_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                state_next = S_FIN;
                if (stat.command == CMD_CREATE) begin
                    cmd.create = 1'b1;
                end else if (stat.command inside {CMD_DESTROY, CMD_ALLOC, CMD_GET, CMD_FREE}) begin
                    if (!stat.inst_ok) begin
                        cmd.set_st  = 1'b1;
                        cmd.st_code = ST_BAD_INST;
                    end else if (stat.command == CMD_DESTROY) begin
                        cmd.kill   = 1'b1;
                        state_next = S_SWEEP;
                    end else if (stat.command == CMD_ALLOC) begin
                        if (stat.pl_zero) begin
                            cmd.set_st  = 1'b1;
                            cmd.st_code = ST_NULL;
                        end else begin
                            state_next = S_AREAD;
                        end
                    end else begin
                        if (stat.h_zero) begin
                            cmd.set_st  = 1'b1;
                            cmd.st_code = ST_EMPTY;
                        end else begin
                            state_next = S_REM;
                        end
                    end
                end
            end
            S_SWEEP: begin
                cmd.sweep_step = 1'b1;
                if (stat.sweep_last) state_next = S_FIN;
            end
            S_AREAD: begin
                cmd.a_read = 1'b1;
                state_next = S_ACHK;
            end
            S_ACHK: begin
                cmd.a_check = 1'b1;
                if (stat.slot_free) begin
                    state_next = S_FIN;
                end else if (stat.tries_last) begin
                    cmd.set_st  = 1'b1;
                    cmd.st_code = ST_FULL;
                    state_next  = S_FIN;
                end else begin
                    state_next = S_AREAD;
                end
            end
            S_REM: begin
                cmd.rem_step = 1'b1;
                if (stat.rem_done) state_next = S_HREAD;
            end
            S_HREAD: begin
                cmd.h_read = 1'b1;
                state_next = S_HCHK;
            end
            S_HCHK: begin
                cmd.h_check = 1'b1;
                state_next  = S_FIN;
            end
            S_FIN: begin
                if (!stat.out_busy) begin
                    cmd.publish = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ----- sv/hta_dp.sv -----
// ----------------------------------------------------------------------------
// hta_dp
// Allocator datapath: instance registers, used-bit and payload memories,
// reciprocal handle reduction and the output register.
// ----------------------------------------------------------------------------
module hta_dp import hta_pkg::*; #(
    parameter int INSTANCES = 8,
    parameter int HANDLES   = 256
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  hta_cmd_t    cmd,
    output hta_stat_t   stat,
    input  logic [2:0]  s_command,
    input  logic [3:0]  s_instance_id,
    input  logic [31:0] s_handle,
    input  logic [47:0] s_payload,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_status,
    output logic [3:0]  m_new_instance,
    output logic [31:0] m_new_handle,
    output logic [47:0] m_read_payload
);

    localparam int IW    = (INSTANCES > 1) ? $clog2(INSTANCES) : 1;
    localparam int SW    = $clog2(HANDLES);
    localparam int AW    = IW + SW;
    localparam int DEPTH = 2 ** AW;
    localparam logic [SW-1:0] HLAST = SW'(HANDLES - 1);
    localparam logic [31:0]   HFULL = 32'(HANDLES);
    localparam logic [31:0]   RECIP = 32'((64'd1 << 32) / HANDLES);

    logic [2:0]    cmd_reg;
    logic [3:0]    id_reg;
    logic          h_zero_reg;
    logic          pl_zero_reg;
    logic [47:0]   pl_reg;
    logic [31:0]   val_reg;
    logic [SW-1:0] rem_reg;
    logic [1:0]    bit_reg;
    logic [31:0]   quo_reg;
    logic [31:0]   qh_reg;
    logic [SW-1:0] tries_reg;
    logic [AW-1:0] sweep_reg;

    logic [INSTANCES-1:0] live_reg;
    logic [31:0]          cnt_reg  [INSTANCES];
    logic [SW-1:0]        slot_reg [INSTANCES];

    logic        used_mem [DEPTH];
    logic [47:0] pay_mem  [DEPTH];
    logic        used_rd;
    logic [47:0] pay_rd;

    logic [2:0]  res_st_reg;
    logic [3:0]  res_inst_reg;
    logic [31:0] res_h_reg;
    logic [47:0] res_pl_reg;

    logic [IW-1:0] idx;
    logic          in_rng;
    logic [63:0]   prod;
    logic [31:0]   r_est;
    logic          free_found;
    logic [IW-1:0] free_idx;
    logic [31:0]   cur_cnt;
    logic [SW-1:0] cur_slot;
    logic [AW-1:0] a_addr;
    logic [AW-1:0] h_addr;
    logic          used_we;
    logic [AW-1:0] used_wa;
    logic          used_wd;

    assign idx      = IW'(id_reg - 4'd1);
    assign in_rng   = (id_reg != 4'd0) && (id_reg <= 4'(INSTANCES));
    assign cur_cnt  = cnt_reg[idx];
    assign cur_slot = slot_reg[idx];
    assign a_addr   = {idx, cur_slot};
    assign h_addr   = {idx, rem_reg};
    assign prod     = {32'd0, val_reg} * {32'd0, RECIP};
    assign r_est    = val_reg - qh_reg;

    always_comb begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = INSTANCES - 1; i >= 0; i--) begin
            if (!live_reg[i]) begin
                free_found = 1'b1;
                free_idx   = IW'(i);
            end
        end
    end

    always_comb begin
        stat            = '0;
        stat.command    = cmd_reg;
        stat.inst_ok    = in_rng && live_reg[idx];
        stat.pl_zero    = pl_zero_reg;
        stat.h_zero     = h_zero_reg;
        stat.rem_done   = (bit_reg == 2'd2);
        stat.sweep_last = (sweep_reg[SW-1:0] == HLAST);
        stat.clr_last   = (sweep_reg == {AW{1'b1}});
        stat.slot_free  = !used_rd;
        stat.tries_last = (tries_reg == HLAST);
        stat.out_busy   = m_valid && !m_ready;
    end

    // single write port on the used bits
    always_comb begin
        used_we = 1'b0;
        used_wa = sweep_reg;
        used_wd = 1'b0;
        if (cmd.clr_step || cmd.sweep_step) begin
            used_we = 1'b1;
        end else if (cmd.a_check && !used_rd) begin
            used_we = 1'b1;
            used_wa = a_addr;
            used_wd = 1'b1;
        end else if (cmd.h_check && cmd_reg == CMD_FREE) begin
            used_we = 1'b1;
            used_wa = h_addr;
        end
    end

    always_ff @(posedge aclk) begin
        if (used_we) used_mem[used_wa] <= used_wd;
        if (cmd.a_check && !used_rd) pay_mem[a_addr] <= pl_reg;
        if (cmd.a_read) used_rd <= used_mem[a_addr];
        if (cmd.h_read) begin
            used_rd <= used_mem[h_addr];
            pay_rd  <= pay_mem[h_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            cmd_reg     <= s_command;
            id_reg      <= s_instance_id;
            h_zero_reg  <= (s_handle == 32'd0);
            pl_zero_reg <= (s_payload == 48'd0);
            pl_reg      <= s_payload;
            val_reg     <= s_handle - 32'd1;
            rem_reg     <= '0;
            bit_reg     <= '0;
            tries_reg   <= '0;
        end
        // quotient estimate from the reciprocal, then one correction
        if (cmd.rem_step) begin
            case (bit_reg)
                2'd0: begin
                    quo_reg <= prod[63:32];
                end
                2'd1: begin
                    qh_reg <= quo_reg * HFULL;
                end
                default: begin
                    rem_reg <= (r_est >= HFULL) ? SW'(r_est - HFULL) : r_est[SW-1:0];
                end
            endcase
            bit_reg <= bit_reg + 2'd1;
        end
        if (cmd.a_check) tries_reg <= tries_reg + SW'(1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            live_reg  <= '0;
            sweep_reg <= '0;
            for (int i = 0; i < INSTANCES; i++) begin
                cnt_reg[i]  <= 32'd1;
                slot_reg[i] <= '0;
            end
        end else begin
            if (cmd.clr_step || cmd.sweep_step) sweep_reg <= sweep_reg + AW'(1);
            if (cmd.kill) begin
                live_reg[idx] <= 1'b0;
                sweep_reg     <= {idx, {SW{1'b0}}};
            end
            if (cmd.create && free_found) begin
                live_reg[free_idx] <= 1'b1;
                cnt_reg[free_idx]  <= 32'd1;
                slot_reg[free_idx] <= '0;
            end
            if (cmd.a_check) begin
                if (cur_cnt == 32'hFFFF_FFFF) begin
                    cnt_reg[idx]  <= 32'd1;
                    slot_reg[idx] <= '0;
                end else begin
                    cnt_reg[idx]  <= cur_cnt + 32'd1;
                    slot_reg[idx] <= (cur_slot == HLAST) ? '0 : cur_slot + SW'(1);
                end
            end
        end
    end

    // result staging
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            res_st_reg   <= ST_OK;
            res_inst_reg <= '0;
            res_h_reg    <= '0;
            res_pl_reg   <= '0;
        end
        if (cmd.create) begin
            if (free_found) res_inst_reg <= 4'(free_idx) + 4'd1;
            else            res_st_reg   <= ST_NO_INST;
        end
        if (cmd.a_check && !used_rd) res_h_reg <= cur_cnt;
        if (cmd.h_check && cmd_reg == CMD_GET) begin
            if (used_rd) res_pl_reg <= pay_rd;
            else         res_st_reg <= ST_EMPTY;
        end
        if (cmd.set_st) res_st_reg <= cmd.st_code;
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid <= 1'b0;
        end else if (cmd.publish) begin
            m_valid <= 1'b1;
        end else if (m_ready) begin
            m_valid <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.publish) begin
            m_status       <= res_st_reg;
            m_new_instance <= res_inst_reg;
            m_new_handle   <= res_h_reg;
            m_read_payload <= res_pl_reg;
        end
    end

endmodule

// ----- sv/handle_table_allocator.sv -----
// ----------------------------------------------------------------------------
// handle_table_allocator
// Per-instance handle tables with create, destroy, alloc, get and free
// commands; one result transaction per command transaction.
//
//   channel   direction  ports
//   s_        in         s_valid s_ready s_command s_instance_id s_handle
//                        s_payload
//   m_        out        m_valid m_ready m_status m_new_instance m_new_handle
//                        m_read_payload
//
// get/free: 3-step reciprocal handle reduction, then one memory read; alloc:
// tries one slot at a time, a read then a check, on the single used-bit memory
// port, up to HANDLES slots; destroy: sweeps the HANDLES used bits of the
// instance one per cycle. after reset a clearing pass over all
// 2**(clog2(INSTANCES)+clog2(HANDLES)) used bits runs before s_ready rises.
// a stalled result holds the next command in flight.
// ----------------------------------------------------------------------------
module handle_table_allocator import hta_pkg::*; #(
    parameter int INSTANCES = 8,
    parameter int HANDLES   = 256
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_command,
    input  logic [3:0]  s_instance_id,
    input  logic [31:0] s_handle,
    input  logic [47:0] s_payload,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_status,
    output logic [3:0]  m_new_instance,
    output logic [31:0] m_new_handle,
    output logic [47:0] m_read_payload
);

    hta_cmd_t  cmd;
    hta_stat_t stat;

    hta_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    hta_dp #(
        .INSTANCES (INSTANCES),
        .HANDLES   (HANDLES)
    ) u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .stat           (stat),
        .s_command      (s_command),
        .s_instance_id  (s_instance_id),
        .s_handle       (s_handle),
        .s_payload      (s_payload),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_status       (m_status),
        .m_new_instance (m_new_instance),
        .m_new_handle   (m_new_handle),
        .m_read_payload (m_read_payload)
    );

endmodule

// ----- tb/handle_table_allocator_check.sv -----
// ----------------------------------------------------------------------------
// handle_table_allocator_check
// Watches both channels of the handle table allocator. Each accepted command
// transaction updates a private copy of the instance and slot tables and
// queues the expected result; each accepted result transaction is compared
// field by field with the oldest queued result.
// ----------------------------------------------------------------------------
module handle_table_allocator_check import hta_pkg::*; #(
    parameter int INSTANCES = 8,
    parameter int HANDLES   = 256
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [2:0]  s_command,
    input  logic [3:0]  s_instance_id,
    input  logic [31:0] s_handle,
    input  logic [47:0] s_payload,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [2:0]  m_status,
    input  logic [3:0]  m_new_instance,
    input  logic [31:0] m_new_handle,
    input  logic [47:0] m_read_payload,
    output int          fail_count,
    output int          outstanding
);

    typedef struct packed {
        logic [2:0]  status;
        logic [3:0]  new_instance;
        logic [31:0] new_handle;
        logic [47:0] read_payload;
    } table_result_t;

    logic        live [INSTANCES];
    logic [31:0] counter [INSTANCES];
    logic        used [INSTANCES][HANDLES];
    logic [47:0] stored [INSTANCES][HANDLES];

    table_result_t awaited_results[$];

    function automatic int slot_index(logic [31:0] h);
        return int'((h - 32'd1) % HANDLES);
    endfunction

    function automatic void empty_table(int inst);
        for (int j = 0; j < HANDLES; j++) begin
            used[inst][j] = 1'b0;
            stored[inst][j] = '0;
        end
    endfunction

    function automatic table_result_t apply_command(logic [2:0] cmd, logic [3:0] id,
                                                    logic [31:0] h, logic [47:0] pl);
        table_result_t r;
        int inst;
        int s;
        logic [31:0] c;
        r = '0;
        inst = int'(id) - 1;
        if (cmd == CMD_CREATE) begin
            r.status = ST_NO_INST;
            for (int i = 0; i < INSTANCES; i++) begin
                if (!live[i]) begin
                    live[i] = 1'b1;
                    counter[i] = 32'd1;
                    empty_table(i);
                    r.new_instance = 4'(i + 1);
                    r.status = ST_OK;
                    break;
                end
            end
        end else if (cmd == CMD_DESTROY || cmd == CMD_ALLOC || cmd == CMD_GET
                     || cmd == CMD_FREE) begin
            if (id == 4'd0 || int'(id) > INSTANCES || !live[inst]) begin
                r.status = ST_BAD_INST;
            end else if (cmd == CMD_DESTROY) begin
                empty_table(inst);
                live[inst] = 1'b0;
            end else if (cmd == CMD_ALLOC) begin
                if (pl == '0) begin
                    r.status = ST_NULL;
                end else begin
                    r.status = ST_FULL;
                    for (int i = 0; i < HANDLES; i++) begin
                        c = counter[inst];
                        s = slot_index(c);
                        counter[inst] = (c == 32'hFFFF_FFFF) ? 32'd1 : c + 32'd1;
                        if (!used[inst][s]) begin
                            used[inst][s] = 1'b1;
                            stored[inst][s] = pl;
                            r.new_handle = c;
                            r.status = ST_OK;
                            break;
                        end
                    end
                end
            end else if (h == '0) begin
                r.status = ST_EMPTY;
            end else begin
                s = slot_index(h);
                if (cmd == CMD_GET) begin
                    if (!used[inst][s]) r.status = ST_EMPTY;
                    else r.read_payload = stored[inst][s];
                end else begin
                    used[inst][s] = 1'b0;
                    stored[inst][s] = '0;
                end
            end
        end
        return r;
    endfunction

    always @(posedge aclk) begin
        table_result_t e;
        if (!aresetn) begin
            for (int i = 0; i < INSTANCES; i++) begin
                live[i] = 1'b0;
                counter[i] = 32'd1;
                empty_table(i);
            end
            awaited_results.delete();
            fail_count <= 0;
        end else begin
            if (s_valid && s_ready)
                awaited_results.push_back(apply_command(s_command, s_instance_id,
                                                        s_handle, s_payload));
            if (m_valid && m_ready) begin
                if (awaited_results.size() == 0) begin
                    $error("unexpected result transaction status=%0d", m_status);
                    fail_count <= fail_count + 1;
                end else begin
                    e = awaited_results.pop_front();
                    if (m_status !== e.status || m_new_instance !== e.new_instance
                        || m_new_handle !== e.new_handle
                        || m_read_payload !== e.read_payload) begin
                        if (m_status !== e.status)
                            $error("status expected %0d actual %0d", e.status, m_status);
                        if (m_new_instance !== e.new_instance)
                            $error("new_instance expected %0d actual %0d",
                                   e.new_instance, m_new_instance);
                        if (m_new_handle !== e.new_handle)
                            $error("new_handle expected %0h actual %0h",
                                   e.new_handle, m_new_handle);
                        if (m_read_payload !== e.read_payload)
                            $error("read_payload expected %0h actual %0h",
                                   e.read_payload, m_read_payload);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
        outstanding <= awaited_results.size();
    end

endmodule

// ----- tb/handle_table_allocator_test.sv -----
// ----------------------------------------------------------------------------
// handle_table_allocator_test
// Drives command transactions into the handle table allocator: a directed
// pass over every command and error case, a table fill to the full state
// with a long result hold-off, then random mostly well-formed traffic with
// random idling on both sides and a drain pause. The checker judges the results.
// ----------------------------------------------------------------------------
module handle_table_allocator_test import hta_pkg::*;;

    localparam int WATCHDOG_LIMIT = 30000;
    localparam int RANDOM_ITEMS   = 1650;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [2:0]  s_command = '0;
    logic [3:0]  s_instance_id = '0;
    logic [31:0] s_handle = '0;
    logic [47:0] s_payload = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [2:0]  m_status;
    logic [3:0]  m_new_instance;
    logic [31:0] m_new_handle;
    logic [47:0] m_read_payload;
    int          fail_count;
    int          outstanding;
    int          idle_cycles = 0;
    int          hold_off = 0;
    logic        quiet = 1'b0;

    always #4 aclk = ~aclk;

    handle_table_allocator dut (.*);

    handle_table_allocator_check checker_i (.*);

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        @(posedge aclk);
        wait (aresetn);
        forever begin
            @(posedge aclk);
            if (hold_off > 0) begin
                m_ready <= 1'b0;
                repeat (hold_off - 1) @(posedge aclk);
                hold_off = 0;
            end else if (quiet || $urandom_range(0, 5) != 0) begin
                m_ready <= 1'b1;
            end else begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 19) - 1) @(posedge aclk);
            end
        end
    end

    task automatic send(logic [2:0] cmd, logic [3:0] id, logic [31:0] h, logic [47:0] pl);
        s_valid <= 1'b1;
        s_command <= cmd;
        s_instance_id <= id;
        s_handle <= h;
        s_payload <= pl;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
    endtask

    initial begin
        logic [2:0]  cmd;
        logic [3:0]  id;
        logic [31:0] h;
        logic [47:0] pl;
        int          pick;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        repeat (9) send(CMD_CREATE, 4'd0, '0, '0);
        send(CMD_ALLOC, 4'd1, '0, 48'hFFFF_FFFF_FFFF);
        send(CMD_ALLOC, 4'd1, '1, 48'd0);
        send(CMD_ALLOC, 4'd0, '0, 48'd5);
        send(CMD_ALLOC, 4'd9, '0, 48'd5);
        send(CMD_ALLOC, 4'd15, '0, 48'd5);
        send(CMD_GET, 4'd1, 32'd1, '0);
        send(CMD_GET, 4'd1, 32'd0, '0);
        send(CMD_GET, 4'd1, 32'hFFFF_FFFF, '1);
        send(CMD_GET, 4'd1, 32'd257, '0);
        send(CMD_FREE, 4'd1, 32'd1, '0);
        send(CMD_FREE, 4'd1, 32'd1, '0);
        send(CMD_FREE, 4'd1, 32'd0, '0);
        send(CMD_GET, 4'd1, 32'd1, '0);
        send(CMD_DESTROY, 4'd2, '0, '0);
        send(CMD_ALLOC, 4'd2, '0, 48'd7);
        send(CMD_DESTROY, 4'd2, '0, '0);
        send(CMD_CREATE, 4'd15, '1, '1);
        send(3'd5, 4'd1, 32'd1, 48'd1);
        send(3'd6, 4'd15, '1, '1);
        send(3'd7, 4'd3, 32'd2, 48'd2);
        drain();

        for (int i = 0; i < 258; i++)
            send(CMD_ALLOC, 4'd3, '0, {$urandom(), $urandom()} | 48'd1);
        send(CMD_GET, 4'd3, 32'd300, '0);
        hold_off = 600;
        repeat (12) send(CMD_GET, 4'd3, $urandom_range(1, 256), '0);
        drain();

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 8) cmd = CMD_CREATE;
            else if (pick < 12) cmd = CMD_DESTROY;
            else if (pick < 50) cmd = CMD_ALLOC;
            else if (pick < 75) cmd = CMD_GET;
            else if (pick < 97) cmd = CMD_FREE;
            else cmd = 3'($urandom_range(5, 7));
            id = ($urandom_range(0, 9) != 0) ? 4'($urandom_range(1, 8))
                                             : 4'($urandom_range(0, 15));
            pick = $urandom_range(0, 9);
            h = (pick < 8) ? $urandom_range(1, 600) : (pick == 8) ? 32'd0 : $urandom();
            pl = ($urandom_range(0, 19) != 0) ? {$urandom(), $urandom()} : 48'd0;
            send(cmd, id, h, pl);
            if (n == RANDOM_ITEMS / 2) drain();
            if (n > RANDOM_ITEMS - 200) begin
                quiet = 1'b1;
            end else if ($urandom_range(0, 7) == 0) begin
                s_valid <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge aclk);
            end
        end
        drain();
        repeat (600) @(posedge aclk);
        if (fail_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

// ----- files.f -----
sv/hta_pkg.sv
sv/hta_ctrl.sv
sv/hta_dp.sv
sv/handle_table_allocator.sv
tb/handle_table_allocator_check.sv
tb/handle_table_allocator_test.sv
